### hdl/rpn_pkg.sv
// rpn_pkg: command codes and the request/response types of the arithmetic unit
// no dependencies
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CMD_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 4'd0,
    CMD_ADD  = 4'd1,
    CMD_SUB  = 4'd2,
    CMD_MUL  = 4'd3,
    CMD_DIV  = 4'd4,
    CMD_SQRT = 4'd5,
    CMD_POW  = 4'd6,
    CMD_LOG  = 4'd7,
    CMD_TERN = 4'd8
  } cmd_t;

  typedef struct packed {
    logic              start;
    cmd_t              op;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] u;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic              err;
    logic [WORD_W-1:0] value;
  } alu_rsp_t;

endpackage

### hdl/rpn_if.sv
// rpn_in_if / rpn_out_if: valid/ready channels for tokens and line results
// no dependencies
`timescale 1ns / 1ps

interface rpn_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [31:0] number;
  logic               line_end;
  modport source (output valid, command, number, line_end, input ready);
  modport sink (input valid, command, number, line_end, output ready);
endinterface

interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] answer;
  logic               failed;
  modport source (output valid, answer, failed, input ready);
  modport sink (input valid, answer, failed, output ready);
endinterface

### hdl/rpn_ram.sv
// rpn_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/rpn_alu.sv
// rpn_alu: multi-cycle arithmetic unit with one shared multiplier
// depends on rpn_pkg
`timescale 1ns / 1ps

module rpn_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::alu_req_t req,
  output rpn_pkg::alu_rsp_t rsp
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    A_IDLE, A_DIV, A_SQRT, A_POW_ACC, A_POW_SQR, A_LOG
  } astate_t;

  astate_t           st_r, st_nxt;
  logic [WORD_W-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt, res_r, res_nxt;
  logic [63:0]       p_r, p_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt, done_r, done_nxt, err_r, err_nxt;

  logic [WORD_W-1:0] mul_x, mul_y, abs_t, abs_s, sum, q_nxt;
  logic [63:0]       mul_p;
  logic [32:0]       trial;

  assign abs_t = req.t[31] ? (~req.t + 32'd1) : req.t;
  assign abs_s = req.s[31] ? (~req.s + 32'd1) : req.s;
  assign trial = {acc_r, a_r[31]} - {1'b0, b_r};
  assign sum   = acc_r + b_r;
  assign q_nxt = {a_r[30:0], ~trial[32]};
  assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

  always_comb begin
    case (st_r)
      A_POW_ACC: begin mul_x = acc_r;      mul_y = a_r; end
      A_POW_SQR: begin mul_x = a_r;        mul_y = a_r; end
      A_LOG:     begin mul_x = p_r[31:0];  mul_y = b_r; end
      default:   begin mul_x = req.t;      mul_y = req.s; end
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    err_nxt  = err_r;
    done_nxt = 1'b0;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          err_nxt = 1'b0;
          res_nxt = '0;
          case (req.op)
            CMD_ADD:  begin res_nxt = req.t + req.s; done_nxt = 1'b1; end
            CMD_SUB:  begin res_nxt = req.t - req.s; done_nxt = 1'b1; end
            CMD_MUL:  begin res_nxt = mul_p[31:0];   done_nxt = 1'b1; end
            CMD_TERN: begin
              res_nxt  = (req.t != '0) ? req.s : req.u;
              done_nxt = 1'b1;
            end
            CMD_DIV: begin
              if (req.s == '0) begin
                err_nxt  = 1'b1;
                done_nxt = 1'b1;
              end else begin
                a_nxt   = abs_t;
                b_nxt   = abs_s;
                acc_nxt = '0;
                cnt_nxt = '0;
                neg_nxt = req.t[31] ^ req.s[31];
                st_nxt  = A_DIV;
              end
            end
            CMD_SQRT: begin
              if (req.t[31]) begin
                err_nxt  = 1'b1;
                done_nxt = 1'b1;
              end else begin
                a_nxt   = req.t;
                acc_nxt = '0;
                b_nxt   = 32'h4000_0000;
                st_nxt  = A_SQRT;
              end
            end
            CMD_POW: begin
              if (req.s[31]) begin
                err_nxt  = 1'b1;
                done_nxt = 1'b1;
              end else begin
                acc_nxt = 32'd1;
                a_nxt   = req.t;
                b_nxt   = req.s;
                st_nxt  = A_POW_ACC;
              end
            end
            CMD_LOG: begin
              if ($signed(req.s) <= 32'sd1) begin
                err_nxt  = 1'b1;
                done_nxt = 1'b1;
              end else begin
                a_nxt   = req.t;
                b_nxt   = req.s;
                p_nxt   = {32'd0, req.s};
                acc_nxt = '0;
                st_nxt  = A_LOG;
              end
            end
            default: done_nxt = 1'b1;
          endcase
        end
      end
      A_DIV: begin
        // restoring division, one quotient bit per cycle
        acc_nxt = trial[32] ? {acc_r[30:0], a_r[31]} : trial[31:0];
        a_nxt   = q_nxt;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          res_nxt  = neg_r ? (~q_nxt + 32'd1) : q_nxt;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_SQRT: begin
        if (a_r >= sum) begin
          a_nxt   = a_r - sum;
          acc_nxt = (acc_r >> 1) + b_r;
        end else begin
          acc_nxt = acc_r >> 1;
        end
        b_nxt = b_r >> 2;
        if (b_r == 32'd1) begin
          res_nxt  = acc_nxt;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_POW_ACC: begin
        if (b_r == '0) begin
          res_nxt  = acc_r;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end else begin
          if (b_r[0]) begin
            acc_nxt = mul_p[31:0];
          end
          st_nxt = A_POW_SQR;
        end
      end
      A_POW_SQR: begin
        a_nxt  = mul_p[31:0];
        b_nxt  = b_r >> 1;
        st_nxt = A_POW_ACC;
      end
      A_LOG: begin
        // count powers of the base that stay at or below the value
        if (a_r[31] || (p_r > {32'd0, a_r})) begin
          res_nxt  = acc_r;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end else begin
          acc_nxt = acc_r + 32'd1;
          p_nxt   = mul_p;
        end
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    p_r   <= p_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    err_r <= err_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.err   = err_r;
  assign rsp.value = res_r;

endmodule

### hdl/rpn_stack_calculator_top.sv
// rpn_stack_calculator_top: token sequencer around the operand stack ram and the alu
// depends on rpn_pkg, rpn_if, rpn_ram, rpn_alu
// push or ignored token: no alu pass; add/sub/mul/ternary: no iteration; div iterates per
// quotient bit, sqrt per result bit, pow per exponent bit, log per power counted; each ends
// early on a zero divisor, negative radicand, negative exponent or bad base. one item is worked
// on at a time. a line-end token then waits in S_FIN while the last result is not yet taken.
// reset clears count, error and tally; the stack ram is not cleared.
`timescale 1ns / 1ps

module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  rpn_in_if.sink     in_ch,
  rpn_out_if.source  out_ch
);
  import rpn_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_ALU, S_WAIT, S_END, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt, need, cnt_m1, cnt_m2, cnt_m3, cnt_base;
  logic              err_r, err_nxt, last_r, last_nxt, out_valid_r, out_valid_nxt;
  logic [1:0]        tally_r, tally_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [WORD_W-1:0] t_r, t_nxt, s_r, s_nxt, u_r, u_nxt;
  logic [WORD_W-1:0] ans_r, ans_nxt;
  logic              failed_r, failed_nxt;

  logic              we, re, accept, bad, slot_free;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;
  alu_req_t          req;
  alu_rsp_t          rsp;

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign cnt_m1    = count_r - CW'(1);
  assign cnt_m2    = count_r - CW'(2);
  assign cnt_m3    = count_r - CW'(3);
  assign cnt_base  = count_r - need;
  assign bad       = err_r || (tally_r < 2'd2) || (count_r != CW'(1));

  always_comb begin
    case (cmd_t'(state_r == S_IDLE ? in_ch.command : cmd_r))
      CMD_SQRT: need = CW'(1);
      CMD_TERN: need = CW'(3);
      default:  need = CW'(2);
    endcase
  end

  rpn_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.start = (state_r == S_ALU);
  assign req.op    = cmd_r;
  assign req.t     = t_r;
  assign req.s     = s_r;
  assign req.u     = u_r;

  rpn_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    tally_nxt     = tally_r;
    cmd_nxt       = cmd_r;
    t_nxt         = t_r;
    s_nxt         = s_r;
    u_nxt         = u_r;
    ans_nxt       = ans_r;
    failed_nxt    = failed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we            = 1'b0;
    waddr         = count_r[AW-1:0];
    wdata         = in_ch.number;
    re            = 1'b0;
    raddr         = cnt_m1[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          tally_nxt = (tally_r == 2'd2) ? 2'd2 : tally_r + 2'd1;
          cmd_nxt   = cmd_t'(in_ch.command);
          last_nxt  = in_ch.line_end;
          state_nxt = S_END;
          if (!err_r) begin
            if (in_ch.command == CMD_PUSH) begin
              if (count_r >= CW'(STACK_DEPTH)) begin
                err_nxt = 1'b1;
              end else begin
                we        = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end else if (in_ch.command <= CMD_TERN) begin
              if (count_r < need) begin
                err_nxt = 1'b1;
              end else begin
                re        = 1'b1;
                state_nxt = S_RD1;
              end
            end
          end
        end
      end
      S_RD1: begin
        t_nxt = rdata;
        if (need >= CW'(2)) begin
          re        = 1'b1;
          raddr     = cnt_m2[AW-1:0];
          state_nxt = S_RD2;
        end else begin
          state_nxt = S_ALU;
        end
      end
      S_RD2: begin
        s_nxt = rdata;
        if (need == CW'(3)) begin
          re        = 1'b1;
          raddr     = cnt_m3[AW-1:0];
          state_nxt = S_RD3;
        end else begin
          state_nxt = S_ALU;
        end
      end
      S_RD3: begin
        u_nxt     = rdata;
        state_nxt = S_ALU;
      end
      S_ALU: state_nxt = S_WAIT;
      S_WAIT: begin
        if (rsp.done) begin
          if (rsp.err) begin
            err_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            waddr     = cnt_base[AW-1:0];
            wdata     = rsp.value;
            count_nxt = cnt_base + CW'(1);
          end
          state_nxt = S_END;
        end
      end
      S_END: begin
        // bottom entry is the line value when exactly one is left
        re        = 1'b1;
        raddr     = '0;
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (slot_free) begin
          ans_nxt       = bad ? '0 : rdata;
          failed_nxt    = bad;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          err_nxt       = 1'b0;
          tally_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= 1'b0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r   <= last_nxt;
    cmd_r    <= cmd_nxt;
    t_r      <= t_nxt;
    s_r      <= s_nxt;
    u_r      <= u_nxt;
    ans_r    <= ans_nxt;
    failed_r <= failed_nxt;
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.answer = ans_r;
  assign out_ch.failed = failed_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && slot_free) |=> (count_r == '0 && !err_r && tally_r == 2'd0))
    else $error("line state not cleared after result");

  a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == S_WAIT)
    else $error("alu completion outside wait state");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !rsp.done && !req.start)
    else $error("token taken while alu active");

endmodule
